>>> rtl/uart_bfc_pkg.sv
// ----------------------------------------------------------------------------
// uart_bfc_pkg
// Constants, types and the radix-16 divide step for the baud/frame calculator.
// ----------------------------------------------------------------------------
package uart_bfc_pkg;

	localparam int unsigned CLK_W         = 32;
	localparam int unsigned BAUD_W        = 16;
	localparam int unsigned BITS_PER_STG  = 4;
	localparam int unsigned DIV_STAGES    = CLK_W / BITS_PER_STG;

	localparam logic [7:0] ENABLE_BYTE    = 8'hB8;
	localparam logic [7:0] NINE_BIT_FLAG  = 8'h04;
	localparam logic [7:0] SPEED_FLAG     = 8'h02;

	// stop_bits code that selects two stop bits
	localparam logic [1:0] STOP_TWO       = 2'b10;

	// character size codes for ctrl_c bits 2:1
	localparam logic [1:0] SIZE_5         = 2'b00;
	localparam logic [1:0] SIZE_6         = 2'b01;
	localparam logic [1:0] SIZE_7         = 2'b10;
	localparam logic [1:0] SIZE_8         = 2'b11;

	typedef struct packed {
		logic [BAUD_W-1:0] rem;
		logic [CLK_W-1:0]  wrk;   // dividend bits shift out at top, quotient bits in at bottom
	} div_state_t;

	// Restoring division, BITS_PER_STG quotient bits per call.
	// rem < dvsr on entry keeps the partial remainder within BAUD_W+1 bits.
	function automatic div_state_t div_step(input div_state_t st, input logic [BAUD_W-1:0] dvsr);
		div_state_t        res;
		logic [BAUD_W:0]   r;
		res = st;
		for (int i = 0; i < BITS_PER_STG; i++) begin
			r       = {res.rem, res.wrk[CLK_W-1]};
			res.wrk = {res.wrk[CLK_W-2:0], 1'b0};
			if (r >= {1'b0, dvsr}) begin
				r          = r - {1'b0, dvsr};
				res.wrk[0] = 1'b1;
			end
			res.rem = r[BAUD_W-1:0];
		end
		return res;
	endfunction

endpackage

>>> rtl/uart_baud_and_frame_setup_calc_top.sv
// ----------------------------------------------------------------------------
// uart_baud_and_frame_setup_calc_top
// Pipelined baud divisor and frame-format byte calculator for an AVR-style USART.
// ----------------------------------------------------------------------------
// Usage:
//  - Input words arrive on s_axis (clock, baud, size, parity, stop, speed);
//    each produces exactly one result word on m_axis.
//  - Divisor = floor(clock_hz / baud_rate / 16) - 1, or /8 with double_speed,
//    low 16 bits kept. divisor_error flags zero baud, zero quotient or a
//    quotient above 65536. Zero baud gives divisor 0.
//  - Pipeline: ten register stages: capture, which loads at the accepting
//    edge, eight radix-16 divide stages, one output register.
//  - Throughput: one word per cycle while m_axis_tready does not stall. The
//    32/16 divide is split into eight stages of four restoring steps each; that stage depth sets the latency.
//  - Each stage has its own valid bit and takes a new word when empty or when
//    the next stage takes its word, so bubbles close up and a stall at
//    m_axis_tready backs up stage by stage without loss or repetition.
//  - s_axis_tready drops only once every stage and the output hold a word.
//  - Reset (arst_n low) clears all valid bits; no word is in flight after.
// ----------------------------------------------------------------------------
module uart_baud_and_frame_setup_calc_top
	import uart_bfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] clock_hz, [47:32] baud_rate, [51:48] data_bits,
	// [53:52] parity_mode, [55:54] stop_bits, [56] double_speed, [63:57] zero
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] baud_divisor, [23:16] ctrl_a, [31:24] ctrl_b, [39:32] ctrl_c,
	// [40] divisor_error, [47:41] zero
	output logic [47:0] m_axis_tdata
);

	// input fields
	logic [CLK_W-1:0]  in_clock_hz;
	logic [BAUD_W-1:0] in_baud_rate;
	logic [3:0]        in_data_bits;
	logic [1:0]        in_parity_mode;
	logic [1:0]        in_stop_bits;
	logic              in_double_speed;

	assign in_clock_hz     = s_axis_tdata[31:0];
	assign in_baud_rate    = s_axis_tdata[47:32];
	assign in_data_bits    = s_axis_tdata[51:48];
	assign in_parity_mode  = s_axis_tdata[53:52];
	assign in_stop_bits    = s_axis_tdata[55:54];
	assign in_double_speed = s_axis_tdata[56];

	// frame bytes, formed at capture
	logic [1:0] in_size;
	logic [7:0] in_ctrl_b;
	logic [7:0] in_ctrl_c;

	always_comb begin
		in_ctrl_b = ENABLE_BYTE;
		unique case (in_data_bits)
			4'd9: begin
				in_size   = SIZE_8;
				in_ctrl_b = ENABLE_BYTE | NINE_BIT_FLAG;
			end
			4'd8:    in_size = SIZE_8;
			4'd7:    in_size = SIZE_7;
			4'd6:    in_size = SIZE_6;
			default: in_size = SIZE_5;
		endcase
		in_ctrl_c = {2'b00, in_parity_mode, (in_stop_bits == STOP_TWO), in_size, 1'b0};
	end

	// pipeline: index 0 is the capture stage, 1..DIV_STAGES the divide stages
	localparam int unsigned LAST = DIV_STAGES;

	logic              vld_s  [LAST+1];
	logic              rdy_s  [LAST+1];
	div_state_t        div_s  [LAST+1];
	logic [BAUD_W-1:0] baud_s [LAST+1];
	logic              dbl_s  [LAST+1];
	logic              bz_s   [LAST+1];
	logic [7:0]        cb_s   [LAST+1];
	logic [7:0]        cc_s   [LAST+1];

	// output register
	logic        out_vld_s10;
	logic [15:0] out_div_s10;
	logic        out_dbl_s10;
	logic [7:0]  out_cb_s10;
	logic [7:0]  out_cc_s10;
	logic        out_err_s10;
	logic        out_bz_s10;
	logic        out_rdy;

	assign out_rdy = !out_vld_s10 || m_axis_tready;

	// each stage loads when empty or when its word moves on
	always_comb begin
		rdy_s[LAST] = !vld_s[LAST] || out_rdy;
		for (int k = LAST - 1; k >= 0; k--) begin
			rdy_s[k] = !vld_s[k] || rdy_s[k+1];
		end
	end

	assign s_axis_tready = rdy_s[0];

	// capture stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy_s[0]) begin
			vld_s[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s[0] && s_axis_tvalid) begin
			div_s[0]  <= '{rem: '0, wrk: in_clock_hz};
			baud_s[0] <= in_baud_rate;
			dbl_s[0]  <= in_double_speed;
			bz_s[0]   <= (in_baud_rate == '0);
			cb_s[0]   <= in_ctrl_b;
			cc_s[0]   <= in_ctrl_c;
		end
	end

	// divide stages, four quotient bits each
	for (genvar k = 1; k <= LAST; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy_s[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s[k] && vld_s[k-1]) begin
				div_s[k]  <= div_step(div_s[k-1], baud_s[k-1]);
				baud_s[k] <= baud_s[k-1];
				dbl_s[k]  <= dbl_s[k-1];
				bz_s[k]   <= bz_s[k-1];
				cb_s[k]   <= cb_s[k-1];
				cc_s[k]   <= cc_s[k-1];
			end
		end
	end

	// post-scale by 8 or 16, subtract one, range check
	logic [CLK_W-4:0] qs;
	logic             q_big;
	logic [15:0]      div_nxt;
	logic             err_nxt;

	always_comb begin
		if (dbl_s[LAST]) begin
			qs = div_s[LAST].wrk[CLK_W-1:3];
		end else begin
			qs = {1'b0, div_s[LAST].wrk[CLK_W-1:4]};
		end
		q_big = (qs[CLK_W-4:17] != '0) || (qs[16] && (qs[15:0] != '0));
		if (bz_s[LAST]) begin
			div_nxt = '0;
			err_nxt = 1'b1;
		end else begin
			div_nxt = qs[15:0] - 16'd1;
			err_nxt = (qs == '0) || q_big;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s10 <= 1'b0;
		end else if (out_rdy) begin
			out_vld_s10 <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && vld_s[LAST]) begin
			out_div_s10 <= div_nxt;
			out_dbl_s10 <= dbl_s[LAST];
			out_cb_s10  <= cb_s[LAST];
			out_cc_s10  <= cc_s[LAST];
			out_err_s10 <= err_nxt;
			out_bz_s10  <= bz_s[LAST];
		end
	end

	assign m_axis_tvalid = out_vld_s10;
	assign m_axis_tdata  = {7'b0, out_err_s10, out_cc_s10, out_cb_s10,
		(out_dbl_s10 ? SPEED_FLAG : 8'h00), out_div_s10};

`ifndef ASSERT_OFF
	// accepted word lands in the capture stage
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s[0])
		else $error("accepted word missing from capture stage");

	// last divide stage keeps its word while the output is full and stalled
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAST] && !out_rdy |=> vld_s[LAST])
		else $error("word dropped at last divide stage");

	// zero baud always reports divisor 0 with error
	a_zero_baud: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_s10 && out_bz_s10 |-> (out_div_s10 == 16'd0) && out_err_s10)
		else $error("zero baud result malformed");

	// input stalls only when the pipe is full at the capture stage
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> vld_s[0] && vld_s[1] && out_vld_s10 && !m_axis_tready)
		else $error("input stalled with room in pipeline");
`endif

endmodule

>>> sim/uart_baud_and_frame_setup_calc_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_baud_and_frame_setup_calc_top_tb
// Self-checking bench for the baud divisor and frame-format calculator.
// Drives request words on s_axis, computes each expected setup word in a
// local predictor, and compares every m_axis word field by field in order.
// Covers divisor range corners, zero baud, all frame codes, random traffic
// under several idle/stall mixes, and a long output hold-off that backs up
// the pipeline.
// ----------------------------------------------------------------------------
module uart_baud_and_frame_setup_calc_top_tb
	import uart_bfc_pkg::*;
();

	localparam int unsigned PIPE_LATENCY = 9;       // accept to m_axis_tvalid
	localparam int unsigned CYCLE_LIMIT  = 200000;  // far above slowest legal run
	localparam int unsigned RANDOM_WORDS = 170;     // per idle phase, four phases

	// Request word, first field in the lowest bits (matches s_axis_tdata map).
	typedef struct packed {
		logic [6:0]  pad;
		logic        double_speed;
		logic [1:0]  stop_bits;
		logic [1:0]  parity_mode;
		logic [3:0]  data_bits;
		logic [15:0] baud_rate;
		logic [31:0] clock_hz;
	} uart_req_t;

	// Setup word, first field in the lowest bits (matches m_axis_tdata map).
	typedef struct packed {
		logic [6:0]  pad;
		logic        divisor_error;
		logic [7:0]  ctrl_c;
		logic [7:0]  ctrl_b;
		logic [7:0]  ctrl_a;
		logic [15:0] baud_divisor;
	} uart_setup_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // clock_hz, baud_rate, data_bits, parity, stop, speed
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // divisor, ctrl_a, ctrl_b, ctrl_c, divisor_error

	uart_setup_t setup_q[$];          // predicted setups, oldest first
	uart_setup_t got_setup;
	uart_setup_t want_setup;
	int unsigned mismatch_count = 0;
	int unsigned words_checked  = 0;
	int unsigned cycle_count    = 0;
	int unsigned send_idle_pct  = 0;  // chance per cycle that the sender sits out
	int unsigned recv_stall_pct = 0;  // chance per cycle that m_axis_tready is low
	int unsigned recv_hold_left = 0;  // long hold-off, counted down by the receiver

	uart_baud_and_frame_setup_calc_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor: divisor, error flag and the three control bytes
	// ------------------------------------------------------------------------
	function automatic uart_setup_t calc_uart_setup(input uart_req_t r);
		uart_setup_t s;
		logic [31:0] quot;
		logic [1:0]  size;
		s = '0;
		s.ctrl_b = ENABLE_BYTE;
		if (r.baud_rate == 16'd0) begin
			// no divide at all; divisor forced to zero
			s.baud_divisor  = 16'd0;
			s.divisor_error = 1'b1;
		end else begin
			quot = r.clock_hz / {16'd0, r.baud_rate} / (r.double_speed ? 32'd8 : 32'd16);
			s.baud_divisor  = 16'(quot - 32'd1);   // zero quotient wraps to 0xFFFF
			s.divisor_error = (quot == 32'd0) || (quot > 32'd65536);
		end
		if (r.double_speed)
			s.ctrl_a = SPEED_FLAG;
		case (r.data_bits)
			4'd9: begin
				size = SIZE_8;
				s.ctrl_b = s.ctrl_b | NINE_BIT_FLAG;
			end
			4'd8:    size = SIZE_8;
			4'd7:    size = SIZE_7;
			4'd6:    size = SIZE_6;
			default: size = SIZE_5;   // 5 and every unsupported length
		endcase
		// parity 5:4, two-stop 3, size 2:1
		s.ctrl_c = {2'b00, r.parity_mode, (r.stop_bits == STOP_TWO), size, 1'b0};
		return s;
	endfunction

	function automatic uart_req_t make_req(input logic [31:0] clock_hz,
			input logic [15:0] baud, input logic [3:0] nbits, input logic [1:0] parity,
			input logic [1:0] stop, input logic dbl);
		uart_req_t r;
		r = '0;
		r.clock_hz     = clock_hz;
		r.baud_rate    = baud;
		r.data_bits    = nbits;
		r.parity_mode  = parity;
		r.stop_bits    = stop;
		r.double_speed = dbl;
		return r;
	endfunction

	// Mix of real-world settings, tiny clocks (zero quotient), tiny bauds
	// (huge quotient) and fully random words.
	function automatic uart_req_t random_request();
		uart_req_t   r;
		int unsigned pick;
		r = '0;
		case ($urandom_range(0, 3))
			0: r.clock_hz = $urandom();
			1: begin
				case ($urandom_range(0, 5))
					0:       r.clock_hz = 32'd1000000;
					1:       r.clock_hz = 32'd8000000;
					2:       r.clock_hz = 32'd14745600;
					3:       r.clock_hz = 32'd16000000;
					4:       r.clock_hz = 32'd18432000;
					default: r.clock_hz = 32'd20000000;
				endcase
			end
			2:       r.clock_hz = $urandom_range(0, 4095);
			default: r.clock_hz = $urandom_range(1000000, 32000000);
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 4)
			r.baud_rate = 16'd0;
		else if (pick < 40) begin
			case ($urandom_range(0, 5))
				0:       r.baud_rate = 16'd300;
				1:       r.baud_rate = 16'd2400;
				2:       r.baud_rate = 16'd9600;
				3:       r.baud_rate = 16'd19200;
				4:       r.baud_rate = 16'd38400;
				default: r.baud_rate = 16'd57600;
			endcase
		end else if (pick < 55)
			r.baud_rate = 16'($urandom_range(1, 15));
		else
			r.baud_rate = 16'($urandom_range(0, 65535));
		r.data_bits    = 4'($urandom_range(0, 15));
		r.parity_mode  = 2'($urandom_range(0, 3));
		r.stop_bits    = 2'($urandom_range(0, 3));
		r.double_speed = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Sender: one word per call, random idle cycles ahead of it
	// ------------------------------------------------------------------------
	task automatic send_request(input uart_req_t r);
		@(negedge clk);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= 64'(r);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		setup_q.push_back(calc_uart_setup(r));
	endtask

	// Drop valid, wait out every expected word, then a latency's worth more.
	task automatic wait_for_drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (setup_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off when one is requested
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (recv_hold_left != 0) begin
			m_axis_tready  <= 1'b0;
			recv_hold_left = recv_hold_left - 1;
		end else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH word %0d %s: got 0x%0h expected 0x%0h",
			words_checked, what, got, want);
		mismatch_count++;
	endtask

	// Checker: every accepted m_axis word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_setup = m_axis_tdata;
			if (setup_q.size() == 0)
				report_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
			else begin
				want_setup = setup_q.pop_front();
				if (got_setup.baud_divisor !== want_setup.baud_divisor)
					report_mismatch("baud_divisor", 32'(got_setup.baud_divisor),
						32'(want_setup.baud_divisor));
				if (got_setup.ctrl_a !== want_setup.ctrl_a)
					report_mismatch("ctrl_a", 32'(got_setup.ctrl_a),
						32'(want_setup.ctrl_a));
				if (got_setup.ctrl_b !== want_setup.ctrl_b)
					report_mismatch("ctrl_b", 32'(got_setup.ctrl_b),
						32'(want_setup.ctrl_b));
				if (got_setup.ctrl_c !== want_setup.ctrl_c)
					report_mismatch("ctrl_c", 32'(got_setup.ctrl_c),
						32'(want_setup.ctrl_c));
				if (got_setup.divisor_error !== want_setup.divisor_error)
					report_mismatch("divisor_error", 32'(got_setup.divisor_error),
						32'(want_setup.divisor_error));
			end
			words_checked++;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Divisor corners, zero baud, and every length/parity/stop code.
	task automatic test_directed_corners();
		logic [31:0] clk_hz;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(make_req(32'd0, 16'd0, 4'd0, 2'd0, 2'd0, 1'b0));          // all zero
		send_request(make_req(32'hFFFF_FFFF, 16'hFFFF, 4'hF, 2'd3, 2'd3, 1'b1)); // all ones
		send_request(make_req(32'd16000000, 16'd0, 4'd9, 2'd2, 2'd2, 1'b1));   // zero baud, bytes kept
		send_request(make_req(32'hFFFF_FFFF, 16'd1, 4'd8, 2'd0, 2'd1, 1'b0));  // huge quotient
		send_request(make_req(32'd1048576, 16'd1, 4'd8, 2'd0, 2'd2, 1'b0));    // quotient 65536, ok
		send_request(make_req(32'd1048592, 16'd1, 4'd8, 2'd1, 2'd1, 1'b0));    // 65537, error
		send_request(make_req(32'd524288, 16'd1, 4'd7, 2'd2, 2'd2, 1'b1));     // 2x: 65536
		send_request(make_req(32'd524296, 16'd1, 4'd7, 2'd2, 2'd2, 1'b1));     // 2x: 65537
		send_request(make_req(32'd15, 16'd1, 4'd6, 2'd0, 2'd0, 1'b0));         // zero quotient
		send_request(make_req(32'd16, 16'd1, 4'd5, 2'd0, 2'd0, 1'b0));         // divisor 0
		send_request(make_req(32'd7, 16'd1, 4'd9, 2'd3, 2'd2, 1'b1));          // 2x zero quotient
		send_request(make_req(32'd8, 16'd1, 4'd9, 2'd3, 2'd2, 1'b1));          // 2x divisor 0
		// every data length, with parity/stop/speed walking along
		for (int n = 0; n < 16; n++) begin
			clk_hz = (n % 3 == 0) ? 32'd16000000 : ((n % 3 == 1) ? 32'd8000000 : 32'd14745600);
			send_request(make_req(clk_hz, (n % 2) ? 16'd9600 : 16'd57600, 4'(n),
				2'(n), 2'(n >> 2), 1'(n)));
		end
		wait_for_drain();
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct,
			input int unsigned stall_pct, input int unsigned count);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int unsigned i = 0; i < count; i++)
			send_request(random_request());
		wait_for_drain();
	endtask

	// Long output hold-off while the sender keeps offering: pipeline fills,
	// s_axis_tready must drop, nothing lost or repeated on release.
	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		recv_hold_left = 300;
		for (int i = 0; i < 40; i++)
			send_request(random_request());
		wait_for_drain();   // sender holds off until all setups are back
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_corners();
		test_random_traffic(0, 0, RANDOM_WORDS);
		test_random_traffic(45, 0, RANDOM_WORDS);
		test_output_backpressure();
		test_random_traffic(0, 45, RANDOM_WORDS);
		test_random_traffic(29, 29, RANDOM_WORDS);

		if (setup_q.size() != 0)
			report_mismatch("words never returned", 32'(setup_q.size()), 32'd0);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
